/* src/ldib_pkg.sv */
// Shared types and constants for the LED dimmer with idle breathing.
package ldib_pkg;

    typedef enum logic [2:0] {
        OP_TICK      = 3'd0,
        OP_TOGGLE    = 3'd1,
        OP_ON        = 3'd2,
        OP_OFF       = 3'd3,
        OP_UP        = 3'd4,
        OP_DOWN      = 3'd5,
        OP_ACTIVITY  = 3'd6,
        OP_SET_STYLE = 3'd7
    } opcode_t;

    typedef enum logic [1:0] {
        CFG_DIM_AFTER      = 2'd0,
        CFG_OFF_AFTER      = 2'd1,
        CFG_BREATH_INTERVAL = 2'd2,
        CFG_FADE_STEP      = 2'd3
    } cfg_index_t;

    localparam logic [1:0] STYLE_STEADY = 2'd0;
    localparam logic [1:0] STYLE_BREATH = 2'd1;

    localparam logic [1:0] PHASE_ACTIVE = 2'd0;
    localparam logic [1:0] PHASE_BREATH = 2'd1;
    localparam logic [1:0] PHASE_OFF    = 2'd2;

    localparam logic [15:0] DIM_AFTER_RST       = 16'd30000;
    localparam logic [15:0] OFF_AFTER_RST       = 16'd60000;
    localparam logic [7:0]  BREATH_INTERVAL_RST = 8'd30;
    localparam logic [7:0]  FADE_STEP_RST       = 8'd5;
    localparam logic [7:0]  BREATH_VALUE_RST    = 8'd255;
    localparam logic [15:0] COUNT_MAX           = 16'hFFFF;
    localparam logic [7:0]  DUTY_MAX            = 8'd255;

    typedef struct packed {
        opcode_t    opcode;
        logic [1:0] style_value;
    } ldib_cmd_t;

    typedef struct packed {
        logic [7:0] duty;
        logic [7:0] level;
        logic [1:0] style;
        logic [1:0] idle_phase;
    } ldib_result_t;

endpackage

/* src/ldib_in_stage.sv */
// Input register stage: holds one accepted command until it is processed.
module ldib_in_stage (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [2:0]          s_opcode,
    input  logic [1:0]          s_style_value,
    input  logic                advance,
    output logic                cmd_valid,
    output ldib_pkg::ldib_cmd_t cmd
);

    logic                vld_reg;
    logic                vld_next;
    ldib_pkg::ldib_cmd_t cmd_reg;

    // Slot frees up in the same cycle its item moves on.
    assign s_ready   = !vld_reg || advance;
    assign cmd_valid = vld_reg;
    assign cmd       = cmd_reg;

    always_comb begin
        vld_next = vld_reg;
        if (s_ready) begin
            vld_next = s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            cmd_reg.opcode      <= ldib_pkg::opcode_t'(s_opcode);
            cmd_reg.style_value <= s_style_value;
        end
    end

endmodule

/* src/ldib_core.sv */
// Dimmer state, config registers and the single-pass command update.
module ldib_core #(
    parameter int LEVELS = 5
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [1:0]             cfg_index,
    input  logic [15:0]            cfg_wdata,
    input  logic                   advance,
    input  ldib_pkg::ldib_cmd_t    cmd,
    output ldib_pkg::ldib_result_t result
);

    localparam logic [7:0] LevelMax  = 8'(LEVELS);
    localparam logic [7:0] DutyStep  = 8'(255 / LEVELS);
    localparam logic [7:0] DutyReset = 8'((255 / LEVELS) * LEVELS);
    localparam logic [7:0] DUTY_MAX_L = ldib_pkg::DUTY_MAX;

    logic [15:0] dim_after_reg;
    logic [15:0] off_after_reg;
    logic [7:0]  interval_reg;
    logic [7:0]  fade_step_reg;

    logic [7:0]  level_reg,        level_next;
    logic [7:0]  saved_reg,        saved_next;
    logic [1:0]  style_reg,        style_next;
    logic [1:0]  phase_reg,        phase_next;
    logic [15:0] idle_cnt_reg,     idle_cnt_next;
    logic [15:0] breath_cnt_reg,   breath_cnt_next;
    logic [7:0]  breath_val_reg,   breath_val_next;
    logic        falling_reg,      falling_next;
    logic [7:0]  duty_reg,         duty_next;

    function automatic logic [7:0] duty_of(input logic [7:0] lvl);
        logic [15:0] prod;
        prod = 16'(DutyStep) * 16'(lvl);
        return prod[7:0];
    endfunction

    // Next breathing value: clamped step up or down.
    logic [8:0] ramp_sum;
    logic [7:0] ramp_val;
    always_comb begin
        ramp_sum = {1'b0, breath_val_reg} + {1'b0, fade_step_reg};
        if (falling_reg) begin
            ramp_val = (breath_val_reg > fade_step_reg) ? breath_val_reg - fade_step_reg : 8'd0;
        end else begin
            ramp_val = ramp_sum[8] ? DUTY_MAX_L : ramp_sum[7:0];
        end
    end

    logic [15:0] idle_inc;
    logic [15:0] breath_inc;
    logic [8:0]  level_up;
    assign idle_inc   = (idle_cnt_reg != ldib_pkg::COUNT_MAX) ? idle_cnt_reg + 16'd1
                                                              : idle_cnt_reg;
    assign breath_inc = (breath_cnt_reg != ldib_pkg::COUNT_MAX) ? breath_cnt_reg + 16'd1
                                                                : breath_cnt_reg;
    assign level_up   = {1'b0, level_reg} + 9'd1;

    always_comb begin
        level_next      = level_reg;
        saved_next      = saved_reg;
        style_next      = style_reg;
        phase_next      = phase_reg;
        idle_cnt_next   = idle_cnt_reg;
        breath_cnt_next = breath_cnt_reg;
        breath_val_next = breath_val_reg;
        falling_next    = falling_reg;
        duty_next       = duty_reg;

        // Command is only decoded when it is really moving on.
        if (advance) begin
            unique case (cmd.opcode)
                ldib_pkg::OP_TICK: begin
                    idle_cnt_next   = idle_inc;
                    breath_cnt_next = breath_inc;
                    if (phase_reg == ldib_pkg::PHASE_ACTIVE && idle_inc >= dim_after_reg) begin
                        style_next = ldib_pkg::STYLE_BREATH;
                        phase_next = ldib_pkg::PHASE_BREATH;
                    end
                    if (phase_next == ldib_pkg::PHASE_BREATH && idle_inc >= off_after_reg) begin
                        level_next = 8'd0;
                        duty_next  = 8'd0;
                        style_next = ldib_pkg::STYLE_STEADY;
                        phase_next = ldib_pkg::PHASE_OFF;
                    end
                    if (style_next == ldib_pkg::STYLE_BREATH && level_next != 8'd0
                            && breath_inc >= {8'd0, interval_reg}) begin
                        duty_next       = breath_val_reg;
                        breath_val_next = ramp_val;
                        if (ramp_val == 8'd0 || ramp_val == DUTY_MAX_L) begin
                            falling_next = !falling_reg;
                        end
                        breath_cnt_next = 16'd0;
                    end
                end
                ldib_pkg::OP_TOGGLE: begin
                    if (style_reg == ldib_pkg::STYLE_STEADY) begin
                        level_next = (level_reg != 8'd0) ? 8'd0 : LevelMax;
                        duty_next  = duty_of(level_next);
                        saved_next = level_next;
                    end else if (style_reg == ldib_pkg::STYLE_BREATH) begin
                        level_next = saved_reg;
                        duty_next  = duty_of(saved_reg);
                        style_next = ldib_pkg::STYLE_STEADY;
                    end
                end
                ldib_pkg::OP_ON: begin
                    level_next = saved_reg;
                    duty_next  = duty_of(saved_reg);
                end
                ldib_pkg::OP_OFF: begin
                    level_next = 8'd0;
                    duty_next  = 8'd0;
                end
                ldib_pkg::OP_UP: begin
                    level_next = (level_up > {1'b0, LevelMax}) ? LevelMax : level_up[7:0];
                    duty_next  = duty_of(level_next);
                    saved_next = level_next;
                end
                ldib_pkg::OP_DOWN: begin
                    level_next = (level_reg <= 8'd2) ? 8'd1 : level_reg - 8'd1;
                    duty_next  = duty_of(level_next);
                    saved_next = level_next;
                end
                ldib_pkg::OP_ACTIVITY: begin
                    idle_cnt_next = 16'd0;
                    if (phase_reg != ldib_pkg::PHASE_ACTIVE) begin
                        level_next = saved_reg;
                        duty_next  = duty_of(saved_reg);
                        phase_next = ldib_pkg::PHASE_ACTIVE;
                    end
                end
                ldib_pkg::OP_SET_STYLE: begin
                    style_next = cmd.style_value;
                end
            endcase
        end
    end

    assign result.duty       = duty_next;
    assign result.level      = level_next;
    assign result.style      = style_next;
    assign result.idle_phase = phase_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dim_after_reg <= ldib_pkg::DIM_AFTER_RST;
            off_after_reg <= ldib_pkg::OFF_AFTER_RST;
            interval_reg  <= ldib_pkg::BREATH_INTERVAL_RST;
            fade_step_reg <= ldib_pkg::FADE_STEP_RST;
        end else if (cfg_wr_en) begin
            unique case (ldib_pkg::cfg_index_t'(cfg_index))
                ldib_pkg::CFG_DIM_AFTER:       dim_after_reg <= cfg_wdata;
                ldib_pkg::CFG_OFF_AFTER:       off_after_reg <= cfg_wdata;
                ldib_pkg::CFG_BREATH_INTERVAL: interval_reg  <= cfg_wdata[7:0];
                ldib_pkg::CFG_FADE_STEP:       fade_step_reg <= cfg_wdata[7:0];
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            level_reg      <= LevelMax;
            saved_reg      <= LevelMax;
            style_reg      <= ldib_pkg::STYLE_STEADY;
            phase_reg      <= ldib_pkg::PHASE_ACTIVE;
            idle_cnt_reg   <= 16'd0;
            breath_cnt_reg <= 16'd0;
            breath_val_reg <= ldib_pkg::BREATH_VALUE_RST;
            falling_reg    <= 1'b0;
            duty_reg       <= DutyReset;
        end else if (advance) begin
            level_reg      <= level_next;
            saved_reg      <= saved_next;
            style_reg      <= style_next;
            phase_reg      <= phase_next;
            idle_cnt_reg   <= idle_cnt_next;
            breath_cnt_reg <= breath_cnt_next;
            breath_val_reg <= breath_val_next;
            falling_reg    <= falling_next;
            duty_reg       <= duty_next;
        end
    end

endmodule

/* src/ldib_out_stage.sv */
// Result register: holds one result until the downstream side takes it.
module ldib_out_stage (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cmd_valid,
    input  ldib_pkg::ldib_result_t result,
    output logic                   advance,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [7:0]             m_duty,
    output logic [7:0]             m_level,
    output logic [1:0]             m_style,
    output logic [1:0]             m_idle_phase
);

    logic                   vld_reg;
    logic                   vld_next;
    ldib_pkg::ldib_result_t res_reg;

    // Load when the slot is empty or being drained this cycle.
    assign advance = cmd_valid && (!vld_reg || m_ready);

    always_comb begin
        vld_next = vld_reg;
        if (advance) begin
            vld_next = 1'b1;
        end else if (m_ready) begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            res_reg <= result;
        end
    end

    assign m_valid      = vld_reg;
    assign m_duty       = res_reg.duty;
    assign m_level      = res_reg.level;
    assign m_style      = res_reg.style;
    assign m_idle_phase = res_reg.idle_phase;

endmodule

/* src/led_dimmer_idle_breathing_top.sv */
// Top level of the LED dimmer with idle breathing.
// Each transfer on the s_ side is a 1 ms tick or a user command (toggle, on,
// off, up, down, activity, set style) and yields exactly one result transfer
// on the m_ side with the PWM duty, brightness level, show style and idle
// phase after that item. The block sustains one item per clock while m_ready keeps
// the result register draining: a command sits in the input register, the state
// update is one shallow pass of logic, and the result lands in the output
// register, which drives m_valid. Throughput is set by the single state
// update path and by m_ready; a stalled result register backs up into the
// input register and then drops s_ready. Brightness runs 0..LEVELS with duty
// (255/LEVELS)*level; up saturates at LEVELS and down at 1, both saving the
// level. Idle timing counts ticks: breathing starts at dim_after_ms, the light
// turns off at off_after_ms, and breathing steps the duty by fade_step every
// breath_interval_ms ticks. Config registers (index 0 dim_after_ms, 1
// off_after_ms, 2 breath_interval_ms, 3 fade_step) are written through
// cfg_wr_en/cfg_index/cfg_wdata and must only change while the block is idle.
module led_dimmer_idle_breathing_top #(
    parameter int LEVELS = 5
) (
    input  logic        aclk,
    input  logic        aresetn,
    // config write port
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata,
    // command channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_opcode,
    input  logic [1:0]  s_style_value,
    // result channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_duty,
    output logic [7:0]  m_level,
    output logic [1:0]  m_style,
    output logic [1:0]  m_idle_phase
);

    logic                   advance;   // item moves from input reg to result reg
    logic                   cmd_valid;
    ldib_pkg::ldib_cmd_t    cmd;
    ldib_pkg::ldib_result_t result;

    ldib_in_stage u_in (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_opcode      (s_opcode),
        .s_style_value (s_style_value),
        .advance       (advance),
        .cmd_valid     (cmd_valid),
        .cmd           (cmd)
    );

    // State registers commit on advance, so the next item sees them updated.
    ldib_core #(
        .LEVELS (LEVELS)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .advance   (advance),
        .cmd       (cmd),
        .result    (result)
    );

    ldib_out_stage u_out (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd_valid    (cmd_valid),
        .result       (result),
        .advance      (advance),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_duty       (m_duty),
        .m_level      (m_level),
        .m_style      (m_style),
        .m_idle_phase (m_idle_phase)
    );

endmodule

/* src/ldib_checker.sv */
// Port-level assertions for the LED dimmer, bound to the top level.
module ldib_checker #(
    parameter int LEVELS = 5
) (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_duty,
    input logic [7:0] m_level,
    input logic [1:0] m_idle_phase
);

    localparam logic [7:0] LevelMax = 8'(LEVELS);

    // No result may be pending right after reset.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // Level never leaves 0..LEVELS.
    a_level_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_level <= LevelMax)
        else $error("level above LEVELS");

    // A dark level means a dark LED, breathing included.
    a_dark_duty: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_level == 8'd0) |-> m_duty == 8'd0)
        else $error("nonzero duty at level 0");

    // Idle phase code 3 is never produced.
    a_phase_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_idle_phase != 2'd3)
        else $error("bad idle phase");

    // Stalled result holds.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_duty) && $stable(m_level)))
        else $error("stalled result changed");

endmodule

bind led_dimmer_idle_breathing_top ldib_checker #(.LEVELS(LEVELS)) u_ldib_checker (.*);

/* verif/led_dimmer_idle_breathing_top_tb.sv */
// Self-checking testbench for the LED dimmer with idle breathing.
module led_dimmer_idle_breathing_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LEVELS    = 5;
    localparam int DUTY_STEP = 255 / LEVELS;

    // ------------------------------------------------------------------
    // Clock, reset and DUT ports (every input known from time zero)
    // ------------------------------------------------------------------
    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        cfg_wr_en     = 1'b0;
    logic [1:0]  cfg_index     = ldib_pkg::CFG_DIM_AFTER;
    logic [15:0] cfg_wdata     = '0;
    logic        s_valid       = 1'b0;
    logic        s_ready;
    logic [2:0]  s_opcode      = ldib_pkg::OP_TICK;
    logic [1:0]  s_style_value = 2'd0;
    logic        m_valid;
    logic        m_ready       = 1'b0;
    logic [7:0]  m_duty;
    logic [7:0]  m_level;
    logic [1:0]  m_style;
    logic [1:0]  m_idle_phase;

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    led_dimmer_idle_breathing_top #(
        .LEVELS(LEVELS)
    ) DUT (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_opcode     (s_opcode),
        .s_style_value(s_style_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_duty       (m_duty),
        .m_level      (m_level),
        .m_style      (m_style),
        .m_idle_phase (m_idle_phase)
    );

    // ------------------------------------------------------------------
    // Shared testbench state
    // ------------------------------------------------------------------
    ldib_pkg::ldib_cmd_t    cmd_backlog[$];     // commands waiting for the driver
    ldib_pkg::ldib_result_t lamp_states_due[$]; // predicted lamp state per accepted command
    bit                     idling_on = 1'b1;   // random gaps on both sides
    int                     failures  = 0;

    // Shadow of the config registers, tracks every write we issue.
    logic [15:0] dim_ms_cfg    = ldib_pkg::DIM_AFTER_RST;
    logic [15:0] off_ms_cfg    = ldib_pkg::OFF_AFTER_RST;
    logic [7:0]  breath_ms_cfg = ldib_pkg::BREATH_INTERVAL_RST;
    logic [7:0]  fade_cfg      = ldib_pkg::FADE_STEP_RST;

    // Shadow of the dimmer state.
    logic [7:0]  lvl         = 8'(LEVELS);
    logic [7:0]  saved_lvl   = 8'(LEVELS);
    logic [1:0]  style_q     = ldib_pkg::STYLE_STEADY;
    logic [1:0]  phase_q     = ldib_pkg::PHASE_ACTIVE;
    logic [15:0] idle_ms     = '0;
    logic [15:0] breath_ms   = '0;
    logic [7:0]  breath_duty = ldib_pkg::BREATH_VALUE_RST;
    bit          breath_down = 1'b0;
    logic [7:0]  duty_q      = 8'(DUTY_STEP * LEVELS);

    function automatic logic [7:0] level_duty(logic [7:0] l);
        return 8'(DUTY_STEP * l);
    endfunction

    // Recall the saved level and drive its duty.
    task automatic lamp_on();
        lvl    = saved_lvl;
        duty_q = level_duty(lvl);
    endtask

    // Advance the shadow state by one command and queue the lamp state it leaves.
    task automatic dimmer_update(input ldib_pkg::ldib_cmd_t cmd);
        int ramp;
        case (cmd.opcode)
            ldib_pkg::OP_TICK: begin
                if (idle_ms != ldib_pkg::COUNT_MAX) idle_ms++;
                if (breath_ms != ldib_pkg::COUNT_MAX) breath_ms++;
                if (phase_q == ldib_pkg::PHASE_ACTIVE && idle_ms >= dim_ms_cfg) begin
                    style_q = ldib_pkg::STYLE_BREATH;
                    phase_q = ldib_pkg::PHASE_BREATH;
                end
                if (phase_q == ldib_pkg::PHASE_BREATH && idle_ms >= off_ms_cfg) begin
                    lvl     = '0;
                    duty_q  = '0;
                    style_q = ldib_pkg::STYLE_STEADY;
                    phase_q = ldib_pkg::PHASE_OFF;
                end
                // triangle ramp, direction flips when it hits either rail
                if (style_q == ldib_pkg::STYLE_BREATH && lvl != 0
                        && breath_ms >= breath_ms_cfg) begin
                    duty_q = breath_duty;
                    if (breath_down)
                        ramp = (breath_duty > fade_cfg) ? breath_duty - fade_cfg : 0;
                    else
                        ramp = (breath_duty + fade_cfg > 255) ? 255 : breath_duty + fade_cfg;
                    breath_duty = 8'(ramp);
                    if (ramp == 0 || ramp == 255) breath_down = !breath_down;
                    breath_ms = '0;
                end
            end
            ldib_pkg::OP_TOGGLE: begin
                if (style_q == ldib_pkg::STYLE_STEADY) begin
                    lvl       = (lvl > 0) ? 8'd0 : 8'(LEVELS);
                    duty_q    = level_duty(lvl);
                    saved_lvl = lvl;
                end else if (style_q == ldib_pkg::STYLE_BREATH) begin
                    lamp_on();
                    style_q = ldib_pkg::STYLE_STEADY;
                end
            end
            ldib_pkg::OP_ON: lamp_on();
            ldib_pkg::OP_OFF: begin
                lvl    = '0;
                duty_q = '0;
            end
            ldib_pkg::OP_UP: begin
                lvl       = (lvl + 1 > LEVELS) ? 8'(LEVELS) : lvl + 8'd1;
                duty_q    = level_duty(lvl);
                saved_lvl = lvl;
            end
            ldib_pkg::OP_DOWN: begin
                lvl       = (lvl <= 2) ? 8'd1 : lvl - 8'd1;
                duty_q    = level_duty(lvl);
                saved_lvl = lvl;
            end
            ldib_pkg::OP_ACTIVITY: begin
                idle_ms = '0;
                if (phase_q != ldib_pkg::PHASE_ACTIVE) begin
                    lamp_on();
                    phase_q = ldib_pkg::PHASE_ACTIVE;
                end
            end
            default: style_q = cmd.style_value;
        endcase
        lamp_states_due.push_back('{duty: duty_q, level: lvl, style: style_q,
                                    idle_phase: phase_q});
    endtask

    // ------------------------------------------------------------------
    // Driver: pops the backlog, holds payload until the transfer completes
    // ------------------------------------------------------------------
    int                  send_gap = 0;
    ldib_pkg::ldib_cmd_t cmd_on_bus;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            send_gap = 0;
        end else if (!s_valid || s_ready) begin
            // a command on the bus now is a completed transfer
            if (s_valid) dimmer_update(cmd_on_bus);
            if (send_gap > 0) begin
                send_gap--;
                s_valid <= 1'b0;
            end else if (cmd_backlog.size() != 0 && idling_on && $urandom_range(0, 9) == 0) begin
                send_gap = $urandom_range(0, 6);
                s_valid <= 1'b0;
            end else if (cmd_backlog.size() != 0) begin
                cmd_on_bus = cmd_backlog.pop_front();
                s_valid       <= 1'b1;
                s_opcode      <= cmd_on_bus.opcode;
                s_style_value <= cmd_on_bus.style_value;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: compares each result transfer with the oldest prediction
    // ------------------------------------------------------------------
    int                     sink_gap = 0;
    ldib_pkg::ldib_result_t want;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            sink_gap = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (lamp_states_due.size() == 0) begin
                    $error("result transfer with nothing expected");
                    failures++;
                end else begin
                    want = lamp_states_due.pop_front();
                    if (m_duty !== want.duty) begin
                        $error("duty: expected %0d, got %0d", want.duty, m_duty);
                        failures++;
                    end
                    if (m_level !== want.level) begin
                        $error("level: expected %0d, got %0d", want.level, m_level);
                        failures++;
                    end
                    if (m_style !== want.style) begin
                        $error("style: expected %0d, got %0d", want.style, m_style);
                        failures++;
                    end
                    if (m_idle_phase !== want.idle_phase) begin
                        $error("idle_phase: expected %0d, got %0d", want.idle_phase,
                               m_idle_phase);
                        failures++;
                    end
                end
            end
            // back-pressure in short random bursts
            if (sink_gap > 0) begin
                sink_gap--;
                m_ready <= 1'b0;
            end else if (idling_on && $urandom_range(0, 7) == 0) begin
                sink_gap = $urandom_range(0, 6);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic queue_cmd(input ldib_pkg::opcode_t op, input logic [1:0] sv);
        cmd_backlog.push_back('{opcode: op, style_value: sv});
    endtask

    // Block is quiet: nothing queued, nothing on either bus, nothing owed.
    task automatic wait_quiet();
        do @(negedge aclk);
        while (cmd_backlog.size() != 0 || s_valid || m_valid || lamp_states_due.size() != 0);
    endtask

    // One register write; the shadow copy follows immediately since the
    // block is quiet and no command can reach it before the write lands.
    task automatic write_cfg(input ldib_pkg::cfg_index_t idx, input logic [15:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            ldib_pkg::CFG_DIM_AFTER:       dim_ms_cfg    = val;
            ldib_pkg::CFG_OFF_AFTER:       off_ms_cfg    = val;
            ldib_pkg::CFG_BREATH_INTERVAL: breath_ms_cfg = val[7:0];
            default:                       fade_cfg      = val[7:0];
        endcase
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Mostly ticks with commands sprinkled in.
    task automatic queue_random(input int count);
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 99) < 70)
                queue_cmd(ldib_pkg::OP_TICK, 2'($urandom));
            else
                queue_cmd(ldib_pkg::opcode_t'($urandom_range(1, 7)), 2'($urandom));
        end
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        logic [15:0] dim_pick;
        logic [15:0] off_pick;
        logic [7:0]  interval_pick;
        logic [7:0]  fade_pick;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed, reset config: every command, level rails, toggle in all styles.
        queue_cmd(ldib_pkg::OP_TICK, 2'd0);
        queue_cmd(ldib_pkg::OP_TOGGLE, 2'd0);             // level to 0, saved
        queue_cmd(ldib_pkg::OP_TOGGLE, 2'd3);             // back to full
        repeat (5) queue_cmd(ldib_pkg::OP_DOWN, 2'd1);    // bottoms out at 1
        repeat (5) queue_cmd(ldib_pkg::OP_UP, 2'd2);      // tops out at LEVELS
        queue_cmd(ldib_pkg::OP_OFF, 2'd0);
        queue_cmd(ldib_pkg::OP_DOWN, 2'd0);               // down from dark lands on 1
        queue_cmd(ldib_pkg::OP_OFF, 2'd1);
        queue_cmd(ldib_pkg::OP_ON, 2'd0);                 // recalls saved level
        queue_cmd(ldib_pkg::OP_SET_STYLE, 2'd2);
        queue_cmd(ldib_pkg::OP_TOGGLE, 2'd0);             // ignored in style 2
        queue_cmd(ldib_pkg::OP_SET_STYLE, 2'd3);
        queue_cmd(ldib_pkg::OP_TOGGLE, 2'd0);             // ignored in style 3
        queue_cmd(ldib_pkg::OP_SET_STYLE, 2'd1);
        queue_cmd(ldib_pkg::OP_TOGGLE, 2'd0);             // acts as on, back to steady
        queue_cmd(ldib_pkg::OP_ACTIVITY, 2'd0);
        queue_cmd(ldib_pkg::OP_SET_STYLE, 2'd0);
        wait_quiet();

        // Zero dim threshold, interval and fade: breathing on the first tick, ramp stuck on a rail.
        write_cfg(ldib_pkg::CFG_DIM_AFTER, 16'd0);
        write_cfg(ldib_pkg::CFG_OFF_AFTER, 16'd65535);
        write_cfg(ldib_pkg::CFG_BREATH_INTERVAL, 16'd0);
        write_cfg(ldib_pkg::CFG_FADE_STEP, 16'd0);
        queue_cmd(ldib_pkg::OP_ACTIVITY, 2'd0);
        repeat (3) queue_cmd(ldib_pkg::OP_TICK, 2'd0);
        queue_cmd(ldib_pkg::OP_ACTIVITY, 2'd0);
        queue_cmd(ldib_pkg::OP_TICK, 2'd0);
        wait_quiet();

        // Zero off threshold: breathing and off on the same tick, then wake-ups.
        write_cfg(ldib_pkg::CFG_DIM_AFTER, 16'd1);
        write_cfg(ldib_pkg::CFG_OFF_AFTER, 16'd0);
        write_cfg(ldib_pkg::CFG_BREATH_INTERVAL, 16'd255);
        write_cfg(ldib_pkg::CFG_FADE_STEP, 16'd255);
        queue_cmd(ldib_pkg::OP_ACTIVITY, 2'd0);
        repeat (2) queue_cmd(ldib_pkg::OP_TICK, 2'd0);
        queue_cmd(ldib_pkg::OP_ON, 2'd0);
        queue_cmd(ldib_pkg::OP_ACTIVITY, 2'd0);
        queue_cmd(ldib_pkg::OP_TICK, 2'd0);
        wait_quiet();

        // Random phases: short idle thresholds so breathing and auto-off happen
        // often. The quiet wait before each config change doubles as a full
        // sender pause.
        for (int ph = 0; ph < 5; ph++) begin
            case ($urandom_range(0, 3))
                0:       dim_pick = 16'd1;
                1:       dim_pick = 16'($urandom_range(2, 12));
                2:       dim_pick = 16'($urandom_range(13, 40));
                default: dim_pick = 16'($urandom_range(0, 65535));
            endcase
            off_pick = 16'($urandom_range(1, 80));
            case ($urandom_range(0, 3))
                0:       interval_pick = 8'd0;
                1:       interval_pick = 8'd1;
                2:       interval_pick = 8'($urandom_range(2, 8));
                default: interval_pick = 8'd255;
            endcase
            case ($urandom_range(0, 3))
                0:       fade_pick = 8'd1;
                1:       fade_pick = 8'd255;
                2:       fade_pick = 8'd0;
                default: fade_pick = 8'($urandom_range(2, 254));
            endcase
            write_cfg(ldib_pkg::CFG_DIM_AFTER, dim_pick);
            write_cfg(ldib_pkg::CFG_OFF_AFTER, off_pick);
            write_cfg(ldib_pkg::CFG_BREATH_INTERVAL, {8'd0, interval_pick});
            write_cfg(ldib_pkg::CFG_FADE_STEP, {8'd0, fade_pick});
            queue_random(125);
            wait_quiet();
        end

        // Last part, no gaps: back-to-back items through breathing and auto-off.
        idling_on = 1'b0;
        write_cfg(ldib_pkg::CFG_DIM_AFTER, 16'd3);
        write_cfg(ldib_pkg::CFG_OFF_AFTER, 16'd20);
        write_cfg(ldib_pkg::CFG_BREATH_INTERVAL, 16'd1);
        write_cfg(ldib_pkg::CFG_FADE_STEP, 16'd100);
        queue_cmd(ldib_pkg::OP_ACTIVITY, 2'd0);
        queue_random(100);
        wait_quiet();

        // spare cycles catch any stray result
        repeat (8) @(posedge aclk);
        if (lamp_states_due.size() != 0) begin
            $error("%0d results never arrived", lamp_states_due.size());
            failures++;
        end
        if (failures == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // Watchdog, several times the slowest legal run.
    initial begin
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
